FILE: src/gm3_pkg.sv
// Shared constants and types for the 3x3 gradient magnitude filter.
`default_nettype none
package gm3_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  // Field and counter widths
  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int FH_W    = 13;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CFG_W   = 13;
  localparam int EDGE_MAX = 255;

  // Reset geometry
  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: src/gradient_magnitude_3x3_filter_top.sv
// Top level of the 3x3 gradient magnitude (Prewitt-style) edge filter.
//
// Usage:
//   Grey pixels enter on the s_* stream in raster order, one item per pixel.
//   For every pixel at row >= 2 and column >= 2 one result leaves on the m_*
//   stream: min(|gx|+|gy|, 255) for the pixel one row up and one column left.
//   m_tlast marks the last result of the frame. Border pixels give no result.
//   Frame size is set through cfg_we/cfg_index/cfg_data while the block is
//   idle; values are clamped into [3, 1024] columns and [3, 4096] rows.
// Timing:
//   Throughput is one item per cycle unless a waiting result stalls the read
//   stage. An accepted item passes the registered line buffer read, then the
//   window update and gradient sum into the output register.
//   The line buffers are two 1024 x 8 memories, read and written once a cycle.
// Reset:
//   rst clears counters, window and stage valids and restores 640 x 480.
//   Line buffers are not cleared; the first two rows fill them.
// Back-pressure:
//   While m_tready is low a waiting result holds. Border items still pass; the
//   next item that gives a result waits in the read stage and s_tready drops.
`default_nettype none
module gradient_magnitude_3x3_filter_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Pixel input
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [7:0]               s_tdata,   // [7:0] pixel_value
  // Result output
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] edge_strength
  output logic                          m_tlast,   // frame_end
  // Configuration
  input  wire logic                     cfg_we,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [gm3_pkg::CFG_W-1:0] cfg_data
);

  localparam int PW = gm3_pkg::PIX_W;
  localparam int CW = gm3_pkg::COL_W;
  localparam int RW = gm3_pkg::ROW_W;
  localparam int FWW = gm3_pkg::FW_W;
  localparam int FHW = gm3_pkg::FH_W;

  // Configuration registers
  logic [FWW-1:0] frame_width;
  logic [FHW-1:0] frame_height;
  logic [FWW-1:0] width_in;
  logic [FHW-1:0] height_in;

  assign width_in  = cfg_data[FWW-1:0];
  assign height_in = cfg_data[FHW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gm3_pkg::WIDTH_RESET;
      frame_height <= gm3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gm3_pkg::REG_FRAME_WIDTH: begin
          if (width_in < FWW'(gm3_pkg::MIN_SIZE))
            frame_width <= FWW'(gm3_pkg::MIN_SIZE);
          else if (width_in > FWW'(gm3_pkg::MAX_WIDTH))
            frame_width <= FWW'(gm3_pkg::MAX_WIDTH);
          else
            frame_width <= width_in;
        end
        gm3_pkg::REG_FRAME_HEIGHT: begin
          if (height_in < FHW'(gm3_pkg::MIN_SIZE))
            frame_height <= FHW'(gm3_pkg::MIN_SIZE);
          else if (height_in > FHW'(gm3_pkg::MAX_HEIGHT))
            frame_height <= FHW'(gm3_pkg::MAX_HEIGHT);
          else
            frame_height <= height_in;
        end
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic           in_acc;
  logic           stg_valid;   // item in read stage, line data registered
  logic           stg_emit;    // item yields a result
  logic           stg_last;    // item is the last result of the frame
  logic [PW-1:0]  stg_pix;
  logic [CW-1:0]  stg_col;
  logic           stg_adv;
  logic           res_valid;
  logic [PW-1:0]  res_data;
  logic           res_last;

  assign stg_adv  = stg_valid && (!stg_emit || !res_valid || m_tready);
  assign s_tready = !stg_valid || stg_adv;
  assign in_acc   = s_tvalid && s_tready;

  // Position counters
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          last_col;
  logic          last_row;

  assign last_col = {1'b0, column_count} >= (frame_width - FWW'(1));
  assign last_row = {1'b0, row_count} >= (frame_height - FHW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Line buffers: a holds the previous row, b the row before that
  logic [PW-1:0] row_store_a [gm3_pkg::MAX_WIDTH];
  logic [PW-1:0] row_store_b [gm3_pkg::MAX_WIDTH];
  logic [PW-1:0] mid_rd;
  logic [PW-1:0] top_rd;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_rd <= row_store_a[column_count];
      top_rd <= row_store_b[column_count];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      row_store_a[stg_col] <= stg_pix;
      row_store_b[stg_col] <= mid_rd;
    end
  end

  // Read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_pix  <= s_tdata;
      stg_col  <= column_count;
      stg_emit <= (row_count >= RW'(2)) && (column_count >= CW'(2));
      stg_last <= last_col && last_row;
    end
  end

  // 3x3 window, index = row*3 + column, newest column on the right
  logic [PW-1:0] window_regs [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) window_regs[k] <= '0;
    end else if (stg_adv) begin
      for (int k = 0; k < 3; k++) begin
        window_regs[k*3]   <= window_regs[k*3+1];
        window_regs[k*3+1] <= window_regs[k*3+2];
      end
      window_regs[2] <= top_rd;
      window_regs[5] <= mid_rd;
      window_regs[8] <= stg_pix;
    end
  end

  // Gradients over the window as it will be after the shift
  logic [9:0]  left_sum, right_sum, top_sum, bot_sum;
  logic [10:0] gx, gy;
  logic [9:0]  gx_abs, gy_abs;
  logic [10:0] mag;
  logic [PW-1:0] mag_sat;

  always_comb begin
    left_sum  = 10'(window_regs[1]) + 10'(window_regs[4]) + 10'(window_regs[7]);
    right_sum = 10'(top_rd) + 10'(mid_rd) + 10'(stg_pix);
    top_sum   = 10'(window_regs[1]) + 10'(window_regs[2]) + 10'(top_rd);
    bot_sum   = 10'(window_regs[7]) + 10'(window_regs[8]) + 10'(stg_pix);
    gx = {1'b0, left_sum} - {1'b0, right_sum};
    gy = {1'b0, top_sum} - {1'b0, bot_sum};
    gx_abs = gx[10] ? 10'(-gx) : gx[9:0];
    gy_abs = gy[10] ? 10'(-gy) : gy[9:0];
    mag = {1'b0, gx_abs} + {1'b0, gy_abs};
    mag_sat = (mag > 11'(gm3_pkg::EDGE_MAX)) ? PW'(gm3_pkg::EDGE_MAX) : mag[PW-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stg_adv && stg_emit) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_emit) begin
      res_data <= mag_sat;
      res_last <= stg_last;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = res_data;
  assign m_tlast  = res_last;

  // Checks
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> stg_valid)
    else $error("accepted item did not reach the read stage");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_col |=> column_count == '0)
    else $error("column counter did not wrap at end of row");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !m_tready |=> res_valid && $stable(res_data) && $stable(res_last))
    else $error("waiting result overwritten");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    stg_adv && stg_emit |-> !res_valid || m_tready)
    else $error("result written over an undelivered one");

endmodule
`default_nettype wire
